// ===== hw/rtl/bba_pkg.sv =====
// Shared types and codes for the bitmap block allocator.
package bba_pkg;

  typedef enum logic [2:0] {
    OP_CONTIG  = 3'd0,
    OP_SCATTER = 3'd1,
    OP_IDX_START = 3'd2,
    OP_IDX_MEMBER = 3'd3,
    OP_QUERY   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_TAKEN   = 2'd2,
    ST_SKIPPED = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Bitmap block allocator: one bit per block in a RAM, read one entry per cycle.
// After reset a clearing pass writes NUM_BLOCKS entries, one per cycle, before
// the first transaction is taken. A query or index start/member request that needs
// the map reads its block in S_RD, checks it in S_CHK and reports from S_FIN. A
// scattered request walks the map from its start block one entry per cycle. A
// contiguous request walks the same way to find its run, then writes the run one
// block per cycle. The map's single read port sets the walk rate. A finished
// result sits in an output register, so a new request is taken while it waits to
// be read.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              operation_i,
  input  logic [6:0]              block_i,
  input  logic [7:0]              count_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [6:0]              first_block_o,
  output logic [6:0]              last_block_o,
  output logic [7:0]              marked_count_o,
  output logic                    block_allocated_o
);
  import bba_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int PW = AW + 1;
  localparam int CW = (PW > 8) ? PW + 1 : 9;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SCAN, S_MARK, S_SCAT, S_RD, S_CHK, S_FIN
  } state_e;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [6:0]      blk_q, blk_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [AW-1:0]   dptr_q, dptr_d;
  logic            pend_q, pend_d;
  logic            chk_q, chk_d;
  logic [7:0]      run_q, run_d;
  logic [AW-1:0]   first_q, first_d;
  logic [AW-1:0]   last_q, last_d;
  logic [7:0]      done_q, done_d;
  status_e         res_st_q, res_st_d;
  logic            res_bit_q, res_bit_d;
  logic [7:0]      members_q, members_d;
  logic            aborted_q, aborted_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_st_q, out_st_d;
  logic [6:0]      out_first_q, out_first_d;
  logic [6:0]      out_last_q, out_last_d;
  logic [7:0]      out_cnt_q, out_cnt_d;
  logic            out_bit_q, out_bit_d;

  logic            we, re, rdata;
  logic [AW-1:0]   waddr, raddr;
  logic            wdata;
  logic            in_range, issue, bit_free;
  logic [CW-1:0]   lo_w;
  logic [7:0]      run_n, done_n;

  bba_ram #(.Width(1), .Depth(NUM_BLOCKS)) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_st_q;
  assign first_block_o     = out_first_q;
  assign last_block_o      = out_last_q;
  assign marked_count_o    = out_cnt_q;
  assign block_allocated_o = out_bit_q;

  assign in_range = CW'(block_i) < CW'(NUM_BLOCKS);
  assign issue    = ptr_q < PW'(NUM_BLOCKS);
  assign bit_free = !rdata;
  assign run_n    = rdata ? 8'd0 : run_q + 8'd1;
  assign done_n   = done_q + 8'd1;
  assign lo_w     = CW'(dptr_q) + CW'(1) - CW'(cnt_q);

  always_comb begin
    state_d = state_q; op_d = op_q; blk_d = blk_q; cnt_d = cnt_q;
    ptr_d = ptr_q; dptr_d = dptr_q; pend_d = 1'b0; chk_d = chk_q;
    run_d = run_q; first_d = first_q; last_d = last_q; done_d = done_q;
    res_st_d = res_st_q; res_bit_d = res_bit_q;
    members_d = members_q; aborted_d = aborted_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_st_d = out_st_q; out_first_d = out_first_q; out_last_d = out_last_q;
    out_cnt_d = out_cnt_q; out_bit_d = out_bit_q;
    we = 1'b0; waddr = ptr_q[AW-1:0]; wdata = 1'b1;
    re = 1'b0; raddr = ptr_q[AW-1:0];

    unique case (state_q)
      S_CLR: begin
        we    = 1'b1;
        wdata = 1'b0;
        ptr_d = ptr_q + PW'(1);
        if (ptr_q[AW-1:0] == AW'(NUM_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_e'(operation_i);
          blk_d     = block_i;
          cnt_d     = count_i;
          ptr_d     = PW'(block_i);
          run_d     = '0;
          done_d    = '0;
          first_d   = '0;
          last_d    = '0;
          res_st_d  = ST_OK;
          res_bit_d = 1'b0;
          chk_d     = 1'b1;
          state_d   = S_FIN;
          case (operation_i)
            OP_CONTIG: begin
              if (count_i == 8'd0) begin
                res_st_d = ST_OK;
              end else if (!in_range) begin
                res_st_d = ST_NOSPACE;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_SCATTER: begin
              if (!in_range) begin
                res_st_d = ST_NOSPACE;
              end else begin
                state_d = S_SCAT;
              end
            end
            OP_IDX_START: begin
              members_d = count_i;
              if (!in_range) begin
                aborted_d = 1'b1;
                res_st_d  = ST_TAKEN;
              end else begin
                state_d = S_RD;
              end
            end
            OP_IDX_MEMBER: begin
              if (members_q == 8'd0) begin
                res_st_d = ST_SKIPPED;
              end else begin
                members_d = members_q - 8'd1;
                if (aborted_q) begin
                  res_st_d = ST_SKIPPED;
                end else if (!in_range) begin
                  aborted_d = 1'b1;
                  res_st_d  = ST_TAKEN;
                end else begin
                  state_d = S_RD;
                end
              end
            end
            OP_QUERY: begin
              if (in_range) begin
                state_d = S_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        re     = issue;
        pend_d = issue;
        dptr_d = ptr_q[AW-1:0];
        if (issue) begin
          ptr_d = ptr_q + PW'(1);
        end
        if (pend_q) begin
          run_d = run_n;
          if (run_n == cnt_q) begin
            first_d = lo_w[AW-1:0];
            last_d  = dptr_q;
            ptr_d   = PW'(lo_w[AW-1:0]);
            done_d  = cnt_q;
            state_d = S_MARK;
          end else if (!issue) begin
            res_st_d = ST_NOSPACE;
            state_d  = S_FIN;
          end
        end
      end

      S_MARK: begin
        we    = 1'b1;
        ptr_d = ptr_q + PW'(1);
        if (ptr_q[AW-1:0] == last_q) begin
          res_st_d = ST_OK;
          state_d  = S_FIN;
        end
      end

      S_SCAT: begin
        re     = issue;
        pend_d = issue;
        dptr_d = ptr_q[AW-1:0];
        if (issue) begin
          ptr_d = ptr_q + PW'(1);
        end
        if (pend_q) begin
          chk_d = 1'b0;
          if (chk_q && !bit_free) begin
            res_st_d = ST_TAKEN;
            state_d  = S_FIN;
          end else begin
            if (bit_free && done_q != cnt_q) begin
              we    = 1'b1;
              waddr = dptr_q;
              if (done_q == 8'd0) begin
                first_d = dptr_q;
              end
              last_d = dptr_q;
              done_d = done_n;
            end
            if (done_d == cnt_q) begin
              res_st_d = ST_OK;
              state_d  = S_FIN;
            end else if (!issue) begin
              res_st_d = ST_NOSPACE;
              state_d  = S_FIN;
            end
          end
        end
      end

      S_RD: begin
        re      = 1'b1;
        raddr   = AW'(blk_q);
        state_d = S_CHK;
      end

      S_CHK: begin
        state_d = S_FIN;
        if (op_q == OP_QUERY) begin
          res_bit_d = rdata;
        end else if (!bit_free) begin
          aborted_d = 1'b1;
          res_st_d  = ST_TAKEN;
        end else begin
          if (op_q == OP_IDX_START) begin
            aborted_d = 1'b0;
          end
          we      = 1'b1;
          waddr   = AW'(blk_q);
          first_d = AW'(blk_q);
          last_d  = AW'(blk_q);
          done_d  = 8'd1;
          res_st_d = ST_OK;
        end
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_first_d = 7'(first_q);
          out_last_d  = 7'(last_q);
          out_cnt_d   = done_q;
          out_bit_d   = res_bit_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      members_q   <= '0;
      aborted_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      members_q   <= members_d;
      aborted_q   <= aborted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    blk_q       <= blk_d;
    cnt_q       <= cnt_d;
    dptr_q      <= dptr_d;
    chk_q       <= chk_d;
    run_q       <= run_d;
    first_q     <= first_d;
    last_q      <= last_d;
    done_q      <= done_d;
    res_st_q    <= res_st_d;
    res_bit_q   <= res_bit_d;
    out_st_q    <= out_st_d;
    out_first_q <= out_first_d;
    out_last_q  <= out_last_d;
    out_cnt_q   <= out_cnt_d;
    out_bit_q   <= out_bit_d;
  end

endmodule

// ===== hw/rtl/bba_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bba_ram #(
  parameter int Width = 1,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/bba_checker.sv =====
// Port-level checks for the bitmap block allocator, bound to the top level.
module bba_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [6:0] first_block_o,
  input logic [6:0] last_block_o,
  input logic [7:0] marked_count_o,
  input logic       block_allocated_o
);
  import bba_pkg::*;

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  // conflicts and skips mark nothing
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_TAKEN || status_o == ST_SKIPPED)
    |-> marked_count_o == 8'd0 && first_block_o == 7'd0 && last_block_o == 7'd0)
    else $error("failed transaction reports marks");

  // only a query reports an allocated bit
  a_query_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_allocated_o |-> status_o == ST_OK && marked_count_o == 8'd0)
    else $error("allocated bit on a marking transaction");

  // nothing marked means zero bounds
  a_zero_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && marked_count_o == 8'd0 |-> first_block_o == 7'd0 && last_block_o == 7'd0)
    else $error("bounds without marks");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .status_o          (status_o),
  .first_block_o     (first_block_o),
  .last_block_o      (last_block_o),
  .marked_count_o    (marked_count_o),
  .block_allocated_o (block_allocated_o)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the bitmap block allocator.
`timescale 1ns / 100ps

module testbench;
  import bba_pkg::*;

  localparam int NBLK = 128;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] first_blk;
    logic [6:0] last_blk;
    logic [7:0] marked;
    logic       alloc_bit;
  } alloc_result_t;

  // Predicts allocator results and compares them with what the block returns.
  class alloc_scoreboard;
    bit            alloc_map [NBLK];
    int unsigned   members_left;
    bit            idx_aborted;
    alloc_result_t pending_q[$];
    int            mismatches;
    int            n_checked;

    function void clear();
      foreach (alloc_map[i]) alloc_map[i] = 0;
      members_left = 0;
      idx_aborted = 0;
      mismatches = 0;
      n_checked = 0;
    endfunction

    function alloc_result_t mk(logic [1:0] s, int f, int l, int m, bit b);
      alloc_result_t r;
      r.status = s;
      r.first_blk = f[6:0];
      r.last_blk = l[6:0];
      r.marked = m[7:0];
      r.alloc_bit = b;
      return r;
    endfunction

    function void note_request(logic [2:0] op, logic [6:0] blk, logic [7:0] cnt);
      int unsigned run, done, first, last, lo;
      alloc_result_t r;
      bit found;
      int b;
      b = blk;
      found = 0;
      r = mk(ST_OK, 0, 0, 0, 0);
      case (op)
        OP_CONTIG: begin
          if (cnt == 0) begin
            r = mk(ST_OK, 0, 0, 0, 0);
          end else begin
            run = 0;
            for (int i = b; i < NBLK && !found; i++) begin
              run = alloc_map[i] ? 0 : run + 1;
              if (run == cnt) begin
                lo = i + 1 - cnt;
                for (int j = lo; j <= i; j++) alloc_map[j] = 1;
                r = mk(ST_OK, lo, i, cnt, 0);
                found = 1;
              end
            end
            if (!found) r = mk(ST_NOSPACE, 0, 0, 0, 0);
          end
        end
        OP_SCATTER: begin
          if (alloc_map[b]) begin
            r = mk(ST_TAKEN, 0, 0, 0, 0);
          end else begin
            done = 0; first = 0; last = 0;
            for (int i = b; i < NBLK && done < cnt; i++) begin
              if (!alloc_map[i]) begin
                alloc_map[i] = 1;
                if (done == 0) first = i;
                last = i;
                done++;
              end
            end
            r = mk(done < cnt ? ST_NOSPACE : ST_OK, first, last, done, 0);
          end
        end
        OP_IDX_START: begin
          members_left = cnt;
          if (alloc_map[b]) begin
            idx_aborted = 1;
            r = mk(ST_TAKEN, 0, 0, 0, 0);
          end else begin
            idx_aborted = 0;
            alloc_map[b] = 1;
            r = mk(ST_OK, b, b, 1, 0);
          end
        end
        OP_IDX_MEMBER: begin
          if (members_left == 0) begin
            r = mk(ST_SKIPPED, 0, 0, 0, 0);
          end else begin
            members_left--;
            if (idx_aborted) begin
              r = mk(ST_SKIPPED, 0, 0, 0, 0);
            end else if (alloc_map[b]) begin
              idx_aborted = 1;
              r = mk(ST_TAKEN, 0, 0, 0, 0);
            end else begin
              alloc_map[b] = 1;
              r = mk(ST_OK, b, b, 1, 0);
            end
          end
        end
        OP_QUERY: r = mk(ST_OK, 0, 0, 0, alloc_map[b]);
        default: r = mk(ST_OK, 0, 0, 0, 0);
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      want = pending_q.pop_front();
      n_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d expected %p got %p", n_checked, want, got);
      end
    endfunction
  endclass

  logic       clk, rst_n;
  logic       in_valid, in_ready, out_valid, out_ready;
  logic [2:0] operation;
  logic [6:0] block;
  logic [7:0] count;
  logic [1:0] status;
  logic [6:0] first_block, last_block;
  logic [7:0] marked_count;
  logic       block_allocated;

  alloc_scoreboard sb;
  int  send_idle_pct, recv_idle_pct;

  bitmap_block_allocator #(.NUM_BLOCKS(NBLK)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .block_i(block), .count_i(count),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .first_block_o(first_block), .last_block_o(last_block),
    .marked_count_o(marked_count), .block_allocated_o(block_allocated)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver: random stall, check on every accepted transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({status, first_block, last_block, marked_count, block_allocated});
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays up after acceptance until the next idle cycle or the next payload
  task automatic send_req(logic [2:0] op, int blk, int cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid  <= 1;
    operation <= op;
    block     <= blk[6:0];
    count     <= cnt[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, blk[6:0], cnt[7:0]);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic int rand_cnt();
    int p;
    p = $urandom_range(99);
    if (p < 60) return $urandom_range(1, 8);
    if (p < 90) return $urandom_range(9, 40);
    return $urandom_range(0, 255);
  endfunction

  task automatic random_part(int n);
    int p, m;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(99);
      if (p < 20) begin
        send_req(OP_CONTIG, $urandom_range(127), rand_cnt());
      end else if (p < 38) begin
        send_req(OP_SCATTER, $urandom_range(127), rand_cnt());
      end else if (p < 63) begin
        // indexed request: a start announcing m members, then up to m random members
        m = $urandom_range(0, 6);
        send_req(OP_IDX_START, $urandom_range(127), m);
        for (int j = 0; j < m && $urandom_range(9) != 0; j++) begin
          send_req(OP_IDX_MEMBER, $urandom_range(127), $urandom_range(255));
          k++;
        end
      end else if (p < 70) begin
        send_req(OP_IDX_MEMBER, $urandom_range(127), $urandom_range(255));
      end else if (p < 92) begin
        send_req(OP_QUERY, $urandom_range(127), $urandom_range(255));
      end else if (p < 97) begin
        send_req(3'($urandom_range(5, 7)), $urandom_range(127), $urandom_range(255));
      end else begin
        // a single query near the top of the map
        send_req(OP_QUERY, $urandom_range(100, 127), 0);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 0;
    in_valid = 0;
    operation = OP_QUERY;
    block = 0;
    count = 0;
    out_ready = 0;
    send_idle_pct = 31;
    recv_idle_pct = 74;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part
    send_req(OP_QUERY, 0, 0);
    send_req(OP_QUERY, 127, 255);
    send_req(OP_CONTIG, 0, 0);
    send_req(OP_SCATTER, 5, 0);
    send_req(OP_CONTIG, 120, 9);
    send_req(OP_CONTIG, 0, 4);
    send_req(OP_CONTIG, 124, 4);
    send_req(OP_SCATTER, 0, 3);
    send_req(OP_SCATTER, 0, 2);
    send_req(OP_SCATTER, 100, 200);
    send_req(OP_QUERY, 127, 0);
    send_req(OP_IDX_START, 10, 3);
    send_req(OP_IDX_MEMBER, 11, 0);
    send_req(OP_IDX_MEMBER, 11, 0);
    send_req(OP_IDX_MEMBER, 12, 0);
    send_req(OP_IDX_MEMBER, 13, 0);
    send_req(OP_IDX_START, 10, 2);
    send_req(OP_IDX_MEMBER, 14, 0);
    send_req(OP_IDX_START, 20, 5);
    send_req(OP_QUERY, 20, 0);
    send_req(OP_IDX_START, 21, 1);
    send_req(OP_IDX_MEMBER, 22, 0);
    send_req(3'd7, 127, 255);
    send_req(3'd5, 42, 128);
    send_req(OP_CONTIG, 30, 128);
    drain();

    random_part(280);
    drain();
    send_idle_pct = 74;
    recv_idle_pct = 31;
    random_part(280);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_part(270);
    drain();

    $display("Summary: %0d results checked over contiguous, scattered, indexed,",
             sb.n_checked);
    $display("  query and unknown requests under three idle mixes.");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bitmap_block_allocator.sv
hw/rtl/bba_checker.sv
tb/testbench.sv
